FILE: hdl/radix_to_digit_string_assert.svh
// assertion macros shared by the radix to digit string design
`ifndef RADIX_TO_DIGIT_STRING_ASSERT_SVH
`define RADIX_TO_DIGIT_STRING_ASSERT_SVH

`ifndef SYNTHESIS

`define RTDS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rtds assertion failed");

`define RTDS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rtds assertion failed");

`else

`define RTDS_ASSERT_IMPLY(label, clk, rstn, ante, cons)

`define RTDS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: hdl/rtds_pkg.sv
// constants, types and helper functions for the radix to digit string converter
`default_nettype none

package rtds_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 32;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int CHAR_W      = 7;
    localparam int STEPS       = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int SHIFT_W     = STEPS * DIGIT_W;
    localparam int STEP_W      = $clog2(STEPS);
    localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W      = $clog2(MAX_DIGITS);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(55);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_LD,
        ST_OUT
    } state_t;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [DIGIT_W:0] div_step(
        input logic [DIGIT_W-1:0] rem,
        input logic               bit_in,
        input logic [RADIX_W-1:0] base
    );
        logic [DIGIT_W:0] partial;
        logic [DIGIT_W:0] diff;
        partial = {rem, bit_in};
        diff    = partial - (DIGIT_W+1)'(base);
        if (partial >= (DIGIT_W+1)'(base)) begin
            return {1'b1, diff[DIGIT_W-1:0]};
        end
        return {1'b0, partial[DIGIT_W-1:0]};
    endfunction

    // digit to ascii glyph
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        if (d < DIGIT_TEN) begin
            return CHAR_ZERO + CHAR_W'(d);
        end
        return CHAR_ALPHA + CHAR_W'(d);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rtds_ram.sv
// generic single write port ram with registered read
`default_nettype none

module rtds_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/radix_to_digit_string.sv
// radix to digit string converter top level
// conversion: four quotient bits a cycle through a 4-bit remainder
// emission: each digit passes through ram read, load and output handshake
// one item at a time: s_ready is high only while no item is in flight
// synchronous active-low reset clears control state; digit ram is not cleared
`default_nettype none
`include "radix_to_digit_string_assert.svh"

module radix_to_digit_string
    import rtds_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [VALUE_WIDTH-1:0] s_value,
    input  wire logic [RADIX_W-1:0]     s_radix,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [CHAR_W-1:0]      m_digit_char,
    output logic                        m_last
);

    state_t               state_reg, state_next;
    logic [SHIFT_W-1:0]   quot_reg, quot_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [RADIX_W-1:0]   base_reg, base_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]    pos_reg, pos_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;

    logic                 ram_we;
    logic [DIGIT_W-1:0]   ram_rdata;
    logic [DIGIT_W-1:0]   div_rem;
    logic [DIGIT_W-1:0]   div_qbits;
    logic [SHIFT_W-1:0]   div_quot;
    logic [RADIX_W-1:0]   radix_clamped;

    // four bit steps of long division on the top chunk
    always_comb begin
        logic [DIGIT_W-1:0] chunk;
        logic [DIGIT_W:0]   res;
        chunk     = quot_reg[SHIFT_W-1 -: DIGIT_W];
        div_rem   = rem_reg;
        div_qbits = '0;
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            res          = div_step(div_rem, chunk[i], base_reg);
            div_qbits[i] = res[DIGIT_W];
            div_rem      = res[DIGIT_W-1:0];
        end
        div_quot = {quot_reg[SHIFT_W-DIGIT_W-1:0], div_qbits};
    end

    always_comb begin
        if (s_radix < RADIX_MIN) begin
            radix_clamped = RADIX_MIN;
        end else if (s_radix > RADIX_MAX) begin
            radix_clamped = RADIX_MAX;
        end else begin
            radix_clamped = s_radix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
        step_reg <= step_next;
        pos_reg  <= pos_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_comb begin
        state_next   = state_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        base_next    = base_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        ram_we       = 1'b0;
        s_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    quot_next  = SHIFT_W'(s_value);
                    base_next  = radix_clamped;
                    rem_next   = '0;
                    step_next  = '0;
                    count_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                quot_next = div_quot;
                rem_next  = div_rem;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    ram_we     = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                    rem_next   = '0;
                    step_next  = '0;
                    if (div_quot == '0 || count_reg == COUNT_W'(MAX_DIGITS - 1)) begin
                        pos_next   = count_reg[ADDR_W-1:0];
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_LD;
            end
            ST_LD: begin
                char_next    = glyph(ram_rdata);
                last_next    = (pos_reg == '0);
                m_valid_next = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next   = pos_reg - ADDR_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    rtds_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (div_rem),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    assign m_valid      = m_valid_reg;
    assign m_digit_char = char_reg;
    assign m_last       = last_reg;

    `RTDS_ASSERT_IMPLY(a_count_in_range, aclk, aresetn, state_reg == ST_DIV, count_reg < COUNT_W'(MAX_DIGITS))
    `RTDS_ASSERT_IMPLY(a_base_clamped, aclk, aresetn, state_reg == ST_DIV, base_reg >= RADIX_MIN && base_reg <= RADIX_MAX)
    `RTDS_ASSERT_IMPLY(a_idle_no_output, aclk, aresetn, s_ready, !m_valid)
    `RTDS_ASSERT_NEXT(a_last_ends_item, aclk, aresetn, m_valid && m_ready && m_last, state_reg == ST_IDLE)

endmodule

`default_nettype wire

FILE: bench/tb.sv
// testbench for radix_to_digit_string: digit scoreboard, item driver and random stalls
`timescale 1ns / 100ps

module tb;
    import rtds_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 400;
    localparam int RANDOM_ITEMS = 320;

    class digit_scoreboard;
        typedef struct packed {
            logic [CHAR_W-1:0] digit_char;
            logic              last;
        } digit_t;

        digit_t pending_digits[$];
        int     errors = 0;

        function void note_item(logic [VALUE_WIDTH-1:0] value, logic [RADIX_W-1:0] radix);
            logic [VALUE_WIDTH-1:0] n;
            int unsigned            base;
            logic [DIGIT_W-1:0]     lsd_first[$];
            string                  glyphs;
            digit_t                 d;
            glyphs = "0123456789ABCDEF";
            n = value;
            base = (radix < 2) ? 2 : (radix > 16) ? 16 : radix;
            do begin
                lsd_first.push_back(DIGIT_W'(n % base));
                n = n / base;
            end while (n != 0 && lsd_first.size() < MAX_DIGITS);
            for (int k = lsd_first.size() - 1; k >= 0; k--) begin
                d.digit_char = CHAR_W'(glyphs[lsd_first[k]]);
                d.last = (k == 0);
                pending_digits.push_back(d);
            end
        endfunction

        function void check_result(logic [CHAR_W-1:0] digit_char, logic last);
            digit_t want;
            if (pending_digits.size() == 0) begin
                $display("%0t: unexpected digit, expected none, actual char %h last %b",
                         $time, digit_char, last);
                errors++;
                return;
            end
            want = pending_digits.pop_front();
            if (digit_char !== want.digit_char) begin
                $display("%0t: digit_char mismatch, expected %h actual %h",
                         $time, want.digit_char, digit_char);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch, expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [VALUE_WIDTH-1:0] s_value = '0;
    logic [RADIX_W-1:0]     s_radix = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [CHAR_W-1:0]      m_digit_char;
    logic                   m_last;
    logic                   calm = 1'b0;

    digit_scoreboard sb = new();

    radix_to_digit_string DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .s_radix      (s_radix),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last       (m_last)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_item(s_value, s_radix);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_digit_char, m_last);
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_item(input logic [VALUE_WIDTH-1:0] value,
                             input logic [RADIX_W-1:0] radix);
        while (!calm && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        s_radix <= radix;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_random_item();
        int unsigned            bits;
        logic [VALUE_WIDTH-1:0] value;
        logic [RADIX_W-1:0]     radix;
        bits = $urandom_range(0, VALUE_WIDTH);
        value = (bits == 0) ? '0 : ($urandom & ({VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - bits)));
        if ($urandom_range(0, 99) < 85) begin
            radix = RADIX_W'($urandom_range(2, 16));
        end else begin
            radix = RADIX_W'($urandom_range(0, 31));
        end
        send_item(value, radix);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero, all ones and single digits
        send_item(32'd0, 5'd10);
        send_item(32'd0, 5'd2);
        send_item(32'hFFFF_FFFF, 5'd2);
        send_item(32'hFFFF_FFFF, 5'd16);
        send_item(32'hFFFF_FFFF, 5'd3);
        send_item(32'hFFFF_FFFF, 5'd10);
        send_item(32'd1, 5'd2);
        send_item(32'd14, 5'd15);
        // saturated bases
        send_item(32'd5, 5'd0);
        send_item(32'd255, 5'd1);
        send_item(32'hDEAD_BEEF, 5'd17);
        send_item(32'h1234_5678, 5'd31);
        // letters and the remaining bases
        send_item(32'hFEDC_BA98, 5'd16);
        send_item(32'h8000_0000, 5'd16);
        send_item(32'd1_000_000_000, 5'd10);
        send_item(32'd4_000_000_000, 5'd4);
        send_item(32'd123_456_789, 5'd5);
        send_item(32'd987_654_321, 5'd6);
        send_item(32'd5_764_801, 5'd7);
        send_item(32'h5555_5555, 5'd8);
        send_item(32'd387_420_488, 5'd9);
        send_item(32'd2_357_947_690, 5'd11);
        send_item(32'hAAAA_AAAA, 5'd12);
        send_item(32'd815_730_720, 5'd13);
        send_item(32'd1_475_789_055, 5'd14);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 120) begin
                calm <= 1'b1;
            end else if (i == 200) begin
                calm <= 1'b0;
            end
            send_random_item();
        end
        s_valid <= 1'b0;

        while (sb.pending_digits.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.pending_digits.size() != 0) begin
            $display("%0t: missing digits, expected %0d more, actual none",
                     $time, sb.pending_digits.size());
            sb.errors++;
        end

        if (sb.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
